// File: design/bmmd_pkg.sv
// Shared types, region codes and address constants for the banked memory map decoder.
// No dependencies; bmmd_decode and the top level refer to this package by scoped names.
package bmmd_pkg;

	localparam logic [3:0] RG_RAM    = 4'd0;
	localparam logic [3:0] RG_BASIC  = 4'd1;
	localparam logic [3:0] RG_KERNAL = 4'd2;
	localparam logic [3:0] RG_CHAR   = 4'd3;
	localparam logic [3:0] RG_VIDEO  = 4'd4;
	localparam logic [3:0] RG_SOUND  = 4'd5;
	localparam logic [3:0] RG_COLOR  = 4'd6;
	localparam logic [3:0] RG_CIA1   = 4'd7;
	localparam logic [3:0] RG_CIA2   = 4'd8;
	localparam logic [3:0] RG_PORT   = 4'd9;
	localparam logic [3:0] RG_NONE   = 4'd10;

	localparam logic [15:0] PORT_ADDR      = 16'h0001;
	localparam logic [7:0]  PORT_RESET     = 8'h37;
	localparam logic [2:0]  BASIC_HI3      = 3'b101;
	localparam logic [2:0]  KERNAL_HI3     = 3'b111;
	localparam logic [3:0]  IO_HI4         = 4'hD;
	localparam logic [1:0]  IO_VIDEO_SEL   = 2'd0;
	localparam logic [1:0]  IO_SOUND_SEL   = 2'd1;
	localparam logic [1:0]  IO_COLOR_SEL   = 2'd2;
	localparam logic [3:0]  IO_CIA1_PAGE   = 4'hC;
	localparam logic [3:0]  IO_CIA2_PAGE   = 4'hD;
	localparam logic [5:0]  VREG_CTRL      = 6'h11;
	localparam logic [5:0]  VREG_CTRL2     = 6'h16;
	localparam logic [5:0]  VREG_MEM_PTR   = 6'h18;
	localparam logic [15:0] CHROM_LO_A     = 16'h1000;
	localparam logic [15:0] CHROM_LO_B     = 16'h9000;
	localparam logic [15:0] CHROM_HI_A     = 16'h1800;
	localparam logic [15:0] CHROM_HI_B     = 16'h9800;
	localparam logic [15:0] CHROM_HI_OFS   = 16'h0800;

	typedef struct packed {
		logic io_visible;
		logic kernal_is_ram;
		logic char_is_ram;
		logic basic_is_ram;
	} bank_flags_t;

	typedef struct packed {
		logic vid_ctrl;
		logic vid_ctrl2;
		logic vid_mem_ptr;
		logic cia2_pa;
		logic port_wr;
	} wr_evt_t;

	function automatic bank_flags_t bank_decode(input logic [2:0] sel);
		bank_flags_t f;
		f = '0;
		unique case (sel)
			3'd0: f = bank_flags_t'(4'h7);
			3'd1: f = bank_flags_t'(4'h5);
			3'd2: f = bank_flags_t'(4'h1);
			3'd3: f = bank_flags_t'(4'h0);
			3'd4: f = bank_flags_t'(4'h7);
			3'd5: f = bank_flags_t'(4'hF);
			3'd6: f = bank_flags_t'(4'hB);
			3'd7: f = bank_flags_t'(4'hA);
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

// File: design/bmmd_req_if.sv
// Request channel interface: one processor bus access with valid/ready handshake.
// No dependencies.
interface bmmd_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] addr;
	logic [7:0]  wdata;

	modport source (output valid, output mode, output addr, output wdata, input ready);
	modport sink (input valid, input mode, input addr, input wdata, output ready);
endinterface

// File: design/bmmd_rsp_if.sv
// Result channel interface: decoded region, offset, port register value and video base addresses.
// No dependencies.
interface bmmd_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  region;
	logic [15:0] offset;
	logic [7:0]  port_value;
	logic [15:0] screen_base;
	logic [15:0] bitmap_base;
	logic        charset_in_rom;
	logic [15:0] charset_addr;

	modport source (output valid, output region, output offset, output port_value,
		output screen_base, output bitmap_base, output charset_in_rom,
		output charset_addr, input ready);
	modport sink (input valid, input region, input offset, input port_value,
		input screen_base, input bitmap_base, input charset_in_rom,
		input charset_addr, output ready);
endinterface

// File: design/bmmd_decode.sv
// Combinational address decoder: region, offset and register-write events of one access.
// Depends on bmmd_pkg.
module bmmd_decode (
	input  logic                 mode,
	input  logic [15:0]          addr,
	input  bmmd_pkg::bank_flags_t flags,
	output logic [3:0]           region,
	output logic [15:0]          offset,
	output bmmd_pkg::wr_evt_t    evt
);

	logic        in_io;
	logic [3:0]  io_rg;
	logic [15:0] io_off;

	assign in_io = addr[15:12] == bmmd_pkg::IO_HI4;

	always_comb begin
		io_rg  = bmmd_pkg::RG_NONE;
		io_off = '0;
		unique case (addr[11:10])
			bmmd_pkg::IO_VIDEO_SEL: begin
				io_rg  = bmmd_pkg::RG_VIDEO;
				io_off = {10'd0, addr[5:0]};
			end
			bmmd_pkg::IO_SOUND_SEL: begin
				io_rg  = bmmd_pkg::RG_SOUND;
				io_off = {11'd0, addr[4:0]};
			end
			bmmd_pkg::IO_COLOR_SEL: begin
				io_rg  = bmmd_pkg::RG_COLOR;
				io_off = {6'd0, addr[9:0]};
			end
			default: begin
				if (addr[11:8] == bmmd_pkg::IO_CIA1_PAGE) begin
					io_rg  = bmmd_pkg::RG_CIA1;
					io_off = {12'd0, addr[3:0]};
				end else if (addr[11:8] == bmmd_pkg::IO_CIA2_PAGE) begin
					io_rg  = bmmd_pkg::RG_CIA2;
					io_off = {12'd0, addr[3:0]};
				end
			end
		endcase
	end

	always_comb begin
		region = bmmd_pkg::RG_RAM;
		offset = addr;
		evt    = '0;
		if (!mode) begin
			if (!flags.basic_is_ram && addr[15:13] == bmmd_pkg::BASIC_HI3) begin
				region = bmmd_pkg::RG_BASIC;
				offset = {3'd0, addr[12:0]};
			end else if (!flags.kernal_is_ram && addr[15:13] == bmmd_pkg::KERNAL_HI3) begin
				region = bmmd_pkg::RG_KERNAL;
				offset = {3'd0, addr[12:0]};
			end else if (flags.io_visible && in_io) begin
				if (io_rg != bmmd_pkg::RG_NONE) begin
					region = io_rg;
					offset = io_off;
				end
			end else if (!flags.char_is_ram && in_io) begin
				region = bmmd_pkg::RG_CHAR;
				offset = {4'd0, addr[11:0]};
			end else if (addr == bmmd_pkg::PORT_ADDR) begin
				region = bmmd_pkg::RG_PORT;
				offset = '0;
			end
		end else begin
			if (flags.io_visible && in_io) begin
				region = io_rg;
				offset = io_off;
				if (io_rg == bmmd_pkg::RG_VIDEO) begin
					evt.vid_ctrl    = io_off[5:0] == bmmd_pkg::VREG_CTRL;
					evt.vid_ctrl2   = io_off[5:0] == bmmd_pkg::VREG_CTRL2;
					evt.vid_mem_ptr = io_off[5:0] == bmmd_pkg::VREG_MEM_PTR;
				end
				evt.cia2_pa = (io_rg == bmmd_pkg::RG_CIA2) && (io_off[3:0] == 4'd0);
			end else if (addr == bmmd_pkg::PORT_ADDR) begin
				region      = bmmd_pkg::RG_PORT;
				offset      = '0;
				evt.port_wr = 1'b1;
			end
		end
	end

endmodule

// File: design/banked_memory_map_decoder.sv
// Top level of the banked memory map decoder: input register, banking state, result register.
// Depends on bmmd_pkg, bmmd_req_if, bmmd_rsp_if and bmmd_decode.
//
// Usage: each request on the req channel is one processor bus access (mode, addr, wdata).
// For every request exactly one result appears on the rsp channel, in order, carrying the
// target region and offset together with the port register and the screen, bitmap and
// character-set bases as they stand after that access.
// A request is registered in the input register when it is accepted and is decoded from there
// against the banking state. Its result is loaded into the result register when that register
// is empty or the receiver takes its current result, which raises rsp.valid.
// Throughput is one request per cycle while the receiver keeps ready high: the input register
// and the result register form a two-stage pipeline, and the banking state is updated in the
// same cycle a request is decoded, so the next request already sees it.
// When the receiver holds ready low, the result register holds its value, the request in the
// input register waits, and req.ready drops once both are full.
// Reset puts the port register at 0x37 with BASIC, KERNAL and I/O visible, the video bank at
// 0x0000, all bases at zero, and empties both pipeline stages.
module banked_memory_map_decoder (
	input  logic       clk,
	input  logic       arst_n,
	bmmd_req_if.sink   req,
	bmmd_rsp_if.source rsp
);

	logic        valid_s1;
	logic        mode_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;

	logic        valid_s2;
	logic [3:0]  region_s2;
	logic [15:0] offset_s2;

	logic [7:0]  port_q;
	logic [15:0] bank_q;
	logic [7:0]  mem_ptr_q;
	logic        bitmap_mode_q;
	logic [15:0] screen_q;
	logic [15:0] bitmap_q;
	logic        charset_rom_q;
	logic [15:0] charset_q;

	logic                  adv_s2;
	logic                  load_s1;
	logic                  fire;
	bmmd_pkg::bank_flags_t flags;
	logic [3:0]            dec_region;
	logic [15:0]           dec_offset;
	bmmd_pkg::wr_evt_t     evt;

	logic [7:0]  port_nx;
	logic [15:0] bank_nx;
	logic [7:0]  mem_ptr_nx;
	logic        bitmap_mode_nx;
	logic        upd_vid;
	logic [15:0] screen_calc;
	logic [15:0] bitmap_calc;
	logic [15:0] char_calc;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign load_s1   = !valid_s1 || adv_s2;
	assign req.ready = load_s1;
	assign fire      = valid_s1 && adv_s2;

	assign flags = bmmd_pkg::bank_decode(port_q[2:0]);

	bmmd_decode u_decode (
		.mode   (mode_s1),
		.addr   (addr_s1),
		.flags  (flags),
		.region (dec_region),
		.offset (dec_offset),
		.evt    (evt)
	);

	always_comb begin
		port_nx        = evt.port_wr ? wdata_s1 : port_q;
		bank_nx        = evt.cia2_pa ? {~wdata_s1[1:0], 14'd0} : bank_q;
		mem_ptr_nx     = evt.vid_mem_ptr ? wdata_s1 : mem_ptr_q;
		bitmap_mode_nx = evt.vid_ctrl ? wdata_s1[5] : bitmap_mode_q;
		upd_vid        = evt.vid_ctrl || evt.vid_ctrl2 || evt.vid_mem_ptr;
		screen_calc    = bank_nx + {2'd0, mem_ptr_nx[7:4], 10'd0};
		bitmap_calc    = bank_nx + {2'd0, mem_ptr_nx[3], 13'd0};
		char_calc      = bank_nx + {2'd0, mem_ptr_nx[3:1], 11'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req.valid) begin
			mode_s1  <= req.mode;
			addr_s1  <= req.addr;
			wdata_s1 <= req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			region_s2 <= dec_region;
			offset_s2 <= dec_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q        <= bmmd_pkg::PORT_RESET;
			bank_q        <= '0;
			mem_ptr_q     <= '0;
			bitmap_mode_q <= 1'b0;
			screen_q      <= '0;
			bitmap_q      <= '0;
			charset_rom_q <= 1'b0;
			charset_q     <= '0;
		end else if (fire) begin
			port_q        <= port_nx;
			bank_q        <= bank_nx;
			mem_ptr_q     <= mem_ptr_nx;
			bitmap_mode_q <= bitmap_mode_nx;
			if (upd_vid || evt.cia2_pa) begin
				screen_q <= screen_calc;
			end
			if ((upd_vid && bitmap_mode_nx) || evt.cia2_pa) begin
				bitmap_q <= bitmap_calc;
			end
			if ((upd_vid && !bitmap_mode_nx) || evt.cia2_pa) begin
				if (char_calc == bmmd_pkg::CHROM_HI_A || char_calc == bmmd_pkg::CHROM_HI_B) begin
					charset_rom_q <= 1'b1;
					charset_q     <= bmmd_pkg::CHROM_HI_OFS;
				end else if (char_calc == bmmd_pkg::CHROM_LO_A
						|| char_calc == bmmd_pkg::CHROM_LO_B) begin
					charset_rom_q <= 1'b1;
					charset_q     <= '0;
				end else begin
					charset_rom_q <= 1'b0;
					charset_q     <= char_calc;
				end
			end
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.region         = region_s2;
	assign rsp.offset         = offset_s2;
	assign rsp.port_value     = port_q;
	assign rsp.screen_base    = screen_q;
	assign rsp.bitmap_base    = bitmap_q;
	assign rsp.charset_in_rom = charset_rom_q;
	assign rsp.charset_addr   = charset_q;

`ifndef SYNTHESIS
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1)
		else $error("Request in the input register was lost during a stall.");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(port_q) && $stable(bank_q) && $stable(screen_q))
		else $error("Banking state changed without a decoded request.");

	a_region_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> region_s2 <= bmmd_pkg::RG_NONE)
		else $error("Result carries an undefined region code.");

	a_port_offset: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (region_s2 == bmmd_pkg::RG_PORT || region_s2 == bmmd_pkg::RG_NONE)
		|-> offset_s2 == '0)
		else $error("Port or dropped access has a nonzero offset.");

	a_charset_rom: assert property (@(posedge clk) disable iff (!arst_n)
		charset_rom_q |-> charset_q == '0 || charset_q == bmmd_pkg::CHROM_HI_OFS)
		else $error("Character ROM selected with an offset outside the ROM.");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for banked_memory_map_decoder: a table of directed bus accesses,
// then random accesses, each checked against a behavioral model of the banking and video state.
// Depends on bmmd_pkg, bmmd_req_if, bmmd_rsp_if and the decoder RTL.
module tb_top;

	localparam logic MODE_RD = 1'b0;
	localparam logic MODE_WR = 1'b1;
	localparam int RANDOM_ACCESSES = 1700;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_WAIT = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;
	localparam int N_DIRECTED = 27;

	localparam bmmd_pkg::bank_flags_t BANK_MAP [0:7] = '{
		bmmd_pkg::bank_flags_t'(4'h7), bmmd_pkg::bank_flags_t'(4'h5),
		bmmd_pkg::bank_flags_t'(4'h1), bmmd_pkg::bank_flags_t'(4'h0),
		bmmd_pkg::bank_flags_t'(4'h7), bmmd_pkg::bank_flags_t'(4'hF),
		bmmd_pkg::bank_flags_t'(4'hB), bmmd_pkg::bank_flags_t'(4'hA)
	};

	typedef struct {
		logic        mode;
		logic [15:0] addr;
		logic [7:0]  wdata;
		bit          typed;
		logic [3:0]  region;
		logic [15:0] offset;
	} access_row_t;

	typedef struct packed {
		logic [3:0]  region;
		logic [15:0] offset;
		logic [7:0]  port_value;
		logic [15:0] screen_base;
		logic [15:0] bitmap_base;
		logic        charset_in_rom;
		logic [15:0] charset_addr;
	} access_result_t;

	logic clk;
	logic arst_n;

	bmmd_req_if req_ch ();
	bmmd_rsp_if rsp_ch ();

	banked_memory_map_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [7:0]            port_reg;
	bmmd_pkg::bank_flags_t flags;
	logic [15:0]           video_bank;
	logic [7:0]            mem_ptr;
	logic                  bitmap_mode;
	logic [15:0]           screen_start;
	logic [15:0]           bitmap_start;
	logic                  charset_rom;
	logic [15:0]           charset_start;

	access_result_t pending_results [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int req_burst = 0;
	int rsp_burst = 0;

	access_row_t directed_rows [N_DIRECTED] = '{
		'{MODE_RD, 16'h0000, 8'h00, 1'b1, bmmd_pkg::RG_RAM,    16'h0000},
		'{MODE_RD, 16'h0001, 8'h00, 1'b1, bmmd_pkg::RG_PORT,   16'h0000},
		'{MODE_RD, 16'hA000, 8'h00, 1'b1, bmmd_pkg::RG_BASIC,  16'h0000},
		'{MODE_RD, 16'hBFFF, 8'h00, 1'b1, bmmd_pkg::RG_BASIC,  16'h1FFF},
		'{MODE_RD, 16'hFFFF, 8'h00, 1'b1, bmmd_pkg::RG_KERNAL, 16'h1FFF},
		'{MODE_RD, 16'hD3FF, 8'h00, 1'b1, bmmd_pkg::RG_VIDEO,  16'h003F},
		'{MODE_RD, 16'hD7FF, 8'h00, 1'b1, bmmd_pkg::RG_SOUND,  16'h001F},
		'{MODE_RD, 16'hDBFF, 8'h00, 1'b1, bmmd_pkg::RG_COLOR,  16'h03FF},
		'{MODE_RD, 16'hDCFF, 8'h00, 1'b1, bmmd_pkg::RG_CIA1,   16'h000F},
		'{MODE_RD, 16'hDFFF, 8'h00, 1'b1, bmmd_pkg::RG_RAM,    16'hDFFF},
		'{MODE_WR, 16'hDE00, 8'hFF, 1'b1, bmmd_pkg::RG_NONE,   16'h0000},
		'{MODE_WR, 16'hA000, 8'h55, 1'b1, bmmd_pkg::RG_RAM,    16'hA000},
		'{MODE_WR, 16'hDD00, 8'h00, 1'b0, bmmd_pkg::RG_CIA2,   16'h0000},
		'{MODE_WR, 16'hD018, 8'h14, 1'b0, bmmd_pkg::RG_VIDEO,  16'h0018},
		'{MODE_WR, 16'hD011, 8'h20, 1'b0, bmmd_pkg::RG_VIDEO,  16'h0011},
		'{MODE_WR, 16'hD3D6, 8'h00, 1'b0, bmmd_pkg::RG_VIDEO,  16'h0016},
		'{MODE_WR, 16'hD018, 8'hFF, 1'b0, bmmd_pkg::RG_VIDEO,  16'h0018},
		'{MODE_WR, 16'hDDF0, 8'h02, 1'b0, bmmd_pkg::RG_CIA2,   16'h0000},
		'{MODE_WR, 16'hD011, 8'h00, 1'b0, bmmd_pkg::RG_VIDEO,  16'h0011},
		'{MODE_WR, 16'hDD00, 8'h03, 1'b0, bmmd_pkg::RG_CIA2,   16'h0000},
		'{MODE_WR, 16'hD018, 8'h16, 1'b0, bmmd_pkg::RG_VIDEO,  16'h0018},
		'{MODE_WR, 16'hD018, 8'h04, 1'b0, bmmd_pkg::RG_VIDEO,  16'h0018},
		'{MODE_WR, 16'h0001, 8'h00, 1'b1, bmmd_pkg::RG_PORT,   16'h0000},
		'{MODE_RD, 16'hD000, 8'h00, 1'b1, bmmd_pkg::RG_RAM,    16'hD000},
		'{MODE_WR, 16'h0001, 8'h33, 1'b1, bmmd_pkg::RG_PORT,   16'h0000},
		'{MODE_RD, 16'hD800, 8'h00, 1'b1, bmmd_pkg::RG_CHAR,   16'h0800},
		'{MODE_WR, 16'h0001, 8'hFF, 1'b1, bmmd_pkg::RG_PORT,   16'h0000}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("banked_memory_map_decoder: mismatch");
			$finish;
		end
	end

	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void io_classify(input logic [15:0] a, output logic [3:0] rg,
		output logic [15:0] off);
		if (a <= 16'hD3FF) begin
			rg = bmmd_pkg::RG_VIDEO;
			off = {10'd0, a[5:0]};
		end else if (a <= 16'hD7FF) begin
			rg = bmmd_pkg::RG_SOUND;
			off = {11'd0, a[4:0]};
		end else if (a <= 16'hDBFF) begin
			rg = bmmd_pkg::RG_COLOR;
			off = a - 16'hD800;
		end else if (a <= 16'hDCFF) begin
			rg = bmmd_pkg::RG_CIA1;
			off = {12'd0, a[3:0]};
		end else if (a <= 16'hDDFF) begin
			rg = bmmd_pkg::RG_CIA2;
			off = {12'd0, a[3:0]};
		end else begin
			rg = bmmd_pkg::RG_NONE;
			off = 16'h0000;
		end
	endfunction

	function automatic void refresh_bases(input bit from_bank);
		logic [15:0] c;
		screen_start = video_bank + {2'b00, mem_ptr[7:4], 10'd0};
		if (bitmap_mode || from_bank)
			bitmap_start = video_bank + (mem_ptr[3] ? 16'h2000 : 16'h0000);
		if (!bitmap_mode || from_bank) begin
			c = video_bank + {2'b00, mem_ptr[3:1], 11'd0};
			if (c == bmmd_pkg::CHROM_HI_A || c == bmmd_pkg::CHROM_HI_B) begin
				charset_rom = 1'b1;
				charset_start = bmmd_pkg::CHROM_HI_OFS;
			end else if (c == bmmd_pkg::CHROM_LO_A || c == bmmd_pkg::CHROM_LO_B) begin
				charset_rom = 1'b1;
				charset_start = 16'h0000;
			end else begin
				charset_rom = 1'b0;
				charset_start = c;
			end
		end
	endfunction

	function automatic access_result_t predict_access(input logic wr, input logic [15:0] a,
		input logic [7:0] d);
		logic [3:0] rg;
		logic [15:0] off;
		logic in_io;
		access_result_t r;
		rg = bmmd_pkg::RG_RAM;
		off = a;
		in_io = (a[15:12] == 4'hD);
		if (!wr) begin
			if (!flags.basic_is_ram && a[15:13] == 3'b101) begin
				rg = bmmd_pkg::RG_BASIC;
				off = a - 16'hA000;
			end else if (!flags.kernal_is_ram && a[15:13] == 3'b111) begin
				rg = bmmd_pkg::RG_KERNAL;
				off = a - 16'hE000;
			end else if (flags.io_visible && in_io) begin
				io_classify(a, rg, off);
				if (rg == bmmd_pkg::RG_NONE) begin
					rg = bmmd_pkg::RG_RAM;
					off = a;
				end
			end else if (!flags.char_is_ram && in_io) begin
				rg = bmmd_pkg::RG_CHAR;
				off = a - 16'hD000;
			end else if (a == bmmd_pkg::PORT_ADDR) begin
				rg = bmmd_pkg::RG_PORT;
				off = 16'h0000;
			end
		end else begin
			if (flags.io_visible && in_io) begin
				io_classify(a, rg, off);
				if (rg == bmmd_pkg::RG_VIDEO) begin
					if (off[5:0] == bmmd_pkg::VREG_CTRL) begin
						bitmap_mode = d[5];
						refresh_bases(1'b0);
					end else if (off[5:0] == bmmd_pkg::VREG_CTRL2) begin
						refresh_bases(1'b0);
					end else if (off[5:0] == bmmd_pkg::VREG_MEM_PTR) begin
						mem_ptr = d;
						refresh_bases(1'b0);
					end
				end else if (rg == bmmd_pkg::RG_CIA2 && off == 16'h0000) begin
					case (d[1:0])
						2'd0: video_bank = 16'hC000;
						2'd1: video_bank = 16'h8000;
						2'd2: video_bank = 16'h4000;
						default: video_bank = 16'h0000;
					endcase
					refresh_bases(1'b1);
				end
			end else if (a == bmmd_pkg::PORT_ADDR) begin
				port_reg = d;
				flags = BANK_MAP[d[2:0]];
				rg = bmmd_pkg::RG_PORT;
				off = 16'h0000;
			end
		end
		r.region = rg;
		r.offset = off;
		r.port_value = port_reg;
		r.screen_base = screen_start;
		r.bitmap_base = bitmap_start;
		r.charset_in_rom = charset_rom;
		r.charset_addr = charset_start;
		return r;
	endfunction

	task automatic send_access(input logic m, input logic [15:0] a, input logic [7:0] d,
		input bit typed, input logic [3:0] rg, input logic [15:0] off);
		int gap;
		access_result_t r;
		gap = draw_gap(req_burst);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.addr <= a;
		req_ch.wdata <= d;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		r = predict_access(m, a, d);
		if (typed) begin
			r.region = rg;
			r.offset = off;
		end
		pending_results.push_back(r);
	endtask

	initial begin
		logic m;
		logic [15:0] a;
		logic [7:0] d;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_RD;
		req_ch.addr <= 16'h0000;
		req_ch.wdata <= 8'h00;
		port_reg = bmmd_pkg::PORT_RESET;
		flags = BANK_MAP[bmmd_pkg::PORT_RESET[2:0]];
		video_bank = 16'h0000;
		mem_ptr = 8'h00;
		bitmap_mode = 1'b0;
		screen_start = 16'h0000;
		bitmap_start = 16'h0000;
		charset_rom = 1'b0;
		charset_start = 16'h0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_access(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].wdata,
				directed_rows[i].typed, directed_rows[i].region, directed_rows[i].offset);

		// Nearly half of the accesses are aimed at the banking and video registers so the state keeps moving.
		for (int n = 0; n < RANDOM_ACCESSES; n++) begin
			m = 1'($urandom_range(0, 1));
			a = 16'($urandom);
			d = 8'($urandom);
			case ($urandom_range(0, 99)) inside
				[0:14]: begin
					m = MODE_WR;
					a = bmmd_pkg::PORT_ADDR;
					if ($urandom_range(0, 1))
						d[2:1] = 2'b11;
				end
				[15:34]: begin
					m = MODE_WR;
					case ($urandom_range(0, 2))
						0: a = {6'b110100, a[9:6], bmmd_pkg::VREG_CTRL};
						1: a = {6'b110100, a[9:6], bmmd_pkg::VREG_CTRL2};
						default: a = {6'b110100, a[9:6], bmmd_pkg::VREG_MEM_PTR};
					endcase
				end
				[35:44]: begin
					m = MODE_WR;
					a = {8'hDD, a[7:4], 4'h0};
				end
				[45:59]: a = 16'hA000 + 16'($urandom_range(0, 16'h5FFF));
				[60:69]: a = 16'($urandom_range(0, 2));
				default: ;
			endcase
			send_access(m, a, d, 1'b0, bmmd_pkg::RG_RAM, 16'h0000);
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("banked_memory_map_decoder: match");
		else
			$display("banked_memory_map_decoder: mismatch");
		$finish;
	end

	initial begin
		int stall;
		access_result_t e;
		access_result_t got;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap(rsp_burst);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got.region = rsp_ch.region;
			got.offset = rsp_ch.offset;
			got.port_value = rsp_ch.port_value;
			got.screen_base = rsp_ch.screen_base;
			got.bitmap_base = rsp_ch.bitmap_base;
			got.charset_in_rom = rsp_ch.charset_in_rom;
			got.charset_addr = rsp_ch.charset_addr;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: region=%0d offset=%h", got.region, got.offset);
			end else begin
				e = pending_results.pop_front();
				if (got.region !== e.region || got.offset !== e.offset
					|| got.port_value !== e.port_value || got.screen_base !== e.screen_base
					|| got.bitmap_base !== e.bitmap_base
					|| got.charset_in_rom !== e.charset_in_rom
					|| got.charset_addr !== e.charset_addr) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("exp: rg=%0d ofs=%h port=%h scr=%h bmp=%h rom=%b chr=%h",
							e.region, e.offset, e.port_value, e.screen_base, e.bitmap_base,
							e.charset_in_rom, e.charset_addr);
						$display("got: rg=%0d ofs=%h port=%h scr=%h bmp=%h rom=%b chr=%h",
							got.region, got.offset, got.port_value, got.screen_base,
							got.bitmap_base, got.charset_in_rom, got.charset_addr);
					end
				end
			end
		end
	end

endmodule

// File: banked_memory_map_decoder.f
design/bmmd_pkg.sv
design/bmmd_req_if.sv
design/bmmd_rsp_if.sv
design/bmmd_decode.sv
design/banked_memory_map_decoder.sv
verif/tb_top.sv
